// ----- rtl/core/text_console_writer_assert.svh -----
// Assertion macros for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TCW_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TCW_ASSERT(lbl, clk, rst, prop, msg)
`define TCW_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ----- rtl/core/tcw_pkg.sv -----
// Package: constants, mode codes and controller/datapath link types.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] RESET_COLOR = 8'h0F;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;

  localparam logic [1:0] MODE_PUT     = 2'd0;
  localparam logic [1:0] MODE_NEWLINE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  typedef struct packed {
    logic take;       // latch the accepted item
    logic calc;       // form address, step cursor
    logic wr_cell;    // write the character cell
    logic rd_cell;    // read the requested cell
    logic sweep_wr;   // write one blank cell of a sweep
    logic sweep_all;  // sweep is the post-reset clear
    logic load_out;   // load the result register
  } tcw_cmd_t;

  typedef struct packed {
    logic is_put;
    logic is_read;
    logic scroll;
    logic sweep_end_all;
    logic sweep_end_row;
    logic out_free;
  } tcw_status_t;

endpackage

// ----- rtl/core/tcw_if.sv -----
// Item channel interfaces: input items and result items.
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, mode, char_code, read_row, read_col, input ready);
  modport sink (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

interface tcw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [7:0] cell_color;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic       scrolled;

  modport source (output valid, cell_char, cell_color, cursor_row, cursor_col, scrolled,
                  input ready);
  modport sink (input valid, cell_char, cell_color, cursor_row, cursor_col, scrolled,
                output ready);
endinterface

// ----- rtl/core/tcw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/tcw_datapath.sv -----
// Datapath: cursor, ring offset, address forming, screen memory, result register.
`include "text_console_writer_assert.svh"

module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  tcw_cmd_t    cmd,
  output tcw_status_t sts,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_color,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic        scrolled
);

  localparam int Cells = ROWS * COLUMNS;
  localparam int RowW  = $clog2(ROWS);
  localparam int ColW  = $clog2(COLUMNS);
  localparam int AddrW = $clog2(Cells);

  logic [1:0]       mode_q;
  logic [7:0]       char_q;
  logic [4:0]       rr_q;
  logic [6:0]       rc_q;
  logic [7:0]       text_color;
  logic [RowW-1:0]  cur_row;
  logic [ColW-1:0]  cur_col;
  logic [RowW-1:0]  top;
  logic [AddrW-1:0] top_base;
  logic [AddrW-1:0] addr_q;
  logic             oor_q;
  logic             scrolled_q;
  logic [AddrW-1:0] sweep_addr;
  logic [ColW-1:0]  sweep_col;

  logic [RowW-1:0]  row_sel;
  logic [ColW-1:0]  col_sel;
  logic [RowW:0]    prow_sum;
  logic [RowW-1:0]  prow;
  logic [AddrW-1:0] addr_next;
  logic             in_range;
  logic             last_col;
  logic             last_row;
  logic [RowW-1:0]  row_next;
  logic [ColW-1:0]  col_next;
  logic             scroll_next;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [15:0]      ram_wdata;
  logic             ram_re;
  logic [15:0]      ram_rdata;
  logic [7:0]       sweep_color;

  // ---- address: logical row through the ring offset ----
  always_comb begin
    if (mode_q == MODE_READ) begin
      row_sel = RowW'(32'(rr_q));
      col_sel = ColW'(32'(rc_q));
    end else begin
      row_sel = cur_row;
      col_sel = cur_col;
    end
    in_range = (32'(rr_q) < ROWS) && (32'(rc_q) < COLUMNS);
    prow_sum = {1'b0, row_sel} + {1'b0, top};
    if (prow_sum >= (RowW+1)'(ROWS)) begin
      prow_sum = prow_sum - (RowW+1)'(ROWS);
    end
    prow      = prow_sum[RowW-1:0];
    addr_next = AddrW'(prow) * AddrW'(COLUMNS) + AddrW'(col_sel);
  end

  // ---- cursor step ----
  always_comb begin
    last_col    = (cur_col == ColW'(COLUMNS - 1));
    last_row    = (cur_row == RowW'(ROWS - 1));
    row_next    = cur_row;
    col_next    = cur_col;
    scroll_next = 1'b0;
    if (mode_q == MODE_PUT) begin
      if (last_col) begin
        col_next = '0;
        if (last_row) begin
          scroll_next = 1'b1;
        end else begin
          row_next = cur_row + 1'b1;
        end
      end else begin
        col_next = cur_col + 1'b1;
      end
    end else if (mode_q == MODE_NEWLINE) begin
      col_next = '0;
      if (last_row) begin
        scroll_next = 1'b1;
      end else begin
        row_next = cur_row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_q <= mode;
      char_q <= char_code;
      rr_q   <= read_row;
      rc_q   <= read_col;
    end
    if (cmd.calc) begin
      addr_q <= addr_next;
      oor_q  <= (mode_q == MODE_READ) && !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color <= cfg_data;
    end
  end

  // Scroll advances the ring top; the old top row becomes the new bottom and is swept.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      top        <= '0;
      top_base   <= '0;
      scrolled_q <= 1'b0;
      sweep_addr <= '0;
      sweep_col  <= '0;
    end else if (cmd.calc) begin
      cur_row    <= row_next;
      cur_col    <= col_next;
      scrolled_q <= scroll_next;
      if (scroll_next) begin
        if (top == RowW'(ROWS - 1)) begin
          top      <= '0;
          top_base <= '0;
        end else begin
          top      <= top + 1'b1;
          top_base <= top_base + AddrW'(COLUMNS);
        end
        sweep_addr <= top_base;
        sweep_col  <= '0;
      end
    end else if (cmd.sweep_wr) begin
      sweep_addr <= sweep_addr + 1'b1;
      sweep_col  <= sweep_col + 1'b1;
    end
  end

  // ---- screen memory ----
  assign sweep_color = cmd.sweep_all ? RESET_COLOR : text_color;
  assign ram_we      = cmd.wr_cell | cmd.sweep_wr;
  assign ram_waddr   = cmd.sweep_wr ? sweep_addr : addr_q;
  assign ram_wdata   = cmd.sweep_wr ? {sweep_color, SPACE_CHAR} : {text_color, char_q};
  assign ram_re      = cmd.rd_cell & !oor_q;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (Cells)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_q),
    .rdata (ram_rdata)
  );

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (mode_q == MODE_READ && !oor_q) begin
        cell_char  <= ram_rdata[7:0];
        cell_color <= ram_rdata[15:8];
      end else begin
        cell_char  <= '0;
        cell_color <= '0;
      end
      cursor_row <= 5'(32'(cur_row));
      cursor_col <= 7'(32'(cur_col));
      scrolled   <= scrolled_q;
    end
  end

  always_comb begin
    sts.is_put        = (mode_q == MODE_PUT);
    sts.is_read       = (mode_q == MODE_READ);
    sts.scroll        = scrolled_q;
    sts.sweep_end_all = (sweep_addr == AddrW'(Cells - 1));
    sts.sweep_end_row = (sweep_col == ColW'(COLUMNS - 1));
    sts.out_free      = !out_valid || out_ready;
  end

  `TCW_ASSERT(a_col_range, clk, rst, 32'(cur_col) < COLUMNS, "cursor column out of range")
  `TCW_ASSERT(a_top_range, clk, rst, 32'(top) < ROWS, "ring top row out of range")
  `TCW_ASSERT(a_scroll_row, clk, rst, scrolled_q |-> last_row, "scroll left cursor off last row")

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
// Controller: sequences reset clear, address, cell access, row sweep and result.
`include "text_console_writer_assert.svh"

module tcw_ctrl import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  tcw_status_t sts,
  output tcw_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_CALC   = 6'b000100,
    ST_ACCESS = 6'b001000,
    ST_SCROLL = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.sweep_wr  = 1'b1;
        cmd.sweep_all = 1'b1;
        if (sts.sweep_end_all) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_ACCESS;
      end
      ST_ACCESS: begin
        cmd.wr_cell = sts.is_put;
        cmd.rd_cell = sts.is_read;
        state_next  = sts.scroll ? ST_SCROLL : ST_FINISH;
      end
      ST_SCROLL: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_end_row) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TCW_NEVER(a_take_wr, clk, rst, cmd.take && (cmd.wr_cell || cmd.sweep_wr), "take during write")
  `TCW_ASSERT(a_load_free, clk, rst, cmd.load_out |-> sts.out_free, "result loaded over an untaken one")
  `TCW_ASSERT(a_take_then_calc, clk, rst, cmd.take |=> cmd.calc, "accepted item not processed")

endmodule

// ----- rtl/core/text_console_writer.sv -----
// Top level of the text console writer.
// Text screen of ROWS x COLUMNS character cells (char in the low byte, attribute in the high
// byte) with a cursor; the screen is a ring of rows in one RAM, so a scroll only moves the
// top-row offset and blanks one row. After reset a clearing pass writes all ROWS*COLUMNS
// cells (2000 by default) before the first item is taken; cfg_we writes are taken throughout.
// Put, newline and read items each pass through accept, address, RAM access and result load;
// an item that scrolls adds, before the result load, a blank of one row (COLUMNS cells, 80 by
// default) written one cell per cycle through the single RAM write port. Results sit in an
// output register, so the next item is accepted while a result waits to be taken.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tcw_in_if.sink     in_ch,
  tcw_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  tcw_cmd_t    cmd;
  tcw_status_t sts;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .mode       (in_ch.mode),
    .char_code  (in_ch.char_code),
    .read_row   (in_ch.read_row),
    .read_col   (in_ch.read_col),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .cell_char  (out_ch.cell_char),
    .cell_color (out_ch.cell_color),
    .cursor_row (out_ch.cursor_row),
    .cursor_col (out_ch.cursor_col),
    .scrolled   (out_ch.scrolled)
  );

endmodule
